// ===== design/lspf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspf_pkg
// shared types, constants and helpers of the scan packet framer
// ----------------------------------------------------------------------------
package lspf_pkg;

    // defaults for top-level parameters
    localparam int SamplesPerPacketDefault = 12;
    localparam int CmdDepthDefault         = 4;

    // packet constants
    localparam logic [7:0] Preamble   = 8'h54;
    localparam logic [7:0] CrcPoly    = 8'h4D;
    localparam logic [7:0] LenVersion = 8'h20;

    // full turn in centidegrees q16.16, and twice that, 33 bits wide
    localparam logic [32:0] FullTurn  = 33'd2359296000;
    localparam logic [32:0] TwoTurns  = 33'd4718592000;

    // configuration register indexes
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 32;
    localparam logic [CfgIndexWidth-1:0] CfgAngularRate = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CfgAngleStep   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CfgMaxRange    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CfgConfidence  = 3'd3;

    // configuration reset values
    localparam logic [15:0] AngularRateReset = 16'd2152;
    localparam logic [31:0] AngleStepReset   = 32'd3134077;
    localparam logic [15:0] MaxRangeReset    = 16'd12000;
    localparam logic [7:0]  ConfidenceReset  = 8'd29;

    // byte positions of a packet, as walked by the back end
    localparam logic [3:0] StepPreamble = 4'd0;
    localparam logic [3:0] StepLength   = 4'd1;
    localparam logic [3:0] StepRateLo   = 4'd2;
    localparam logic [3:0] StepRateHi   = 4'd3;
    localparam logic [3:0] StepStartLo  = 4'd4;
    localparam logic [3:0] StepStartHi  = 4'd5;
    localparam logic [3:0] StepDistLo   = 4'd6;
    localparam logic [3:0] StepDistHi   = 4'd7;
    localparam logic [3:0] StepConf     = 4'd8;
    localparam logic [3:0] StepEndLo    = 4'd9;
    localparam logic [3:0] StepEndHi    = 4'd10;
    localparam logic [3:0] StepTsLo     = 4'd11;
    localparam logic [3:0] StepTsHi     = 4'd12;
    localparam logic [3:0] StepCrc      = 4'd13;

    // one classified sample, front to back
    typedef struct packed {
        logic        hdr;
        logic        trl;
        logic [15:0] start_cd;
        logic [15:0] end_cd;
        logic [15:0] dist_mm;
        logic [7:0]  conf;
    } cmd_t;

    // back end status for checks
    typedef struct packed {
        logic       active;
        logic [3:0] step;
    } back_stat_t;

    // samples per packet, held to 2..31
    function automatic logic [4:0] clamp_samples(input int n);
        logic [4:0] r;
        if (n < 2) r = 5'd2;
        else if (n > 31) r = 5'd31;
        else r = 5'(n);
        return r;
    endfunction

    // crc-8 msb first over one byte
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) c = {c[6:0], 1'b0} ^ CrcPoly;
            else      c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== design/lidar_scan_packet_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_packet_framer
// turns distance samples into the byte stream of rotating-lidar scan packets
// ----------------------------------------------------------------------------
// usage
//   input queue: drive distance_mm and push; a request is taken when full is
//   low. one request is one distance sample in millimetres.
//   output queue: while empty is low, out_byte/pkt_last hold the oldest
//   byte; pop takes it. pkt_last marks the crc byte closing a packet.
//   config: cfg_we/cfg_index/cfg_data write a register; the block does not
//   check that it is idle, the user must. 0 rate, 1 angle step, 2 max range, 3 confidence.
// timing
//   with the back end idle, the first byte of a sample goes through the
//   command queue and then the output register before it is on the output.
//   a sample makes 3 bytes, 9 with the header (first of a packet) or 8 with
//   the trailer (last of a packet); the back end byte walker sends bytes one
//   per cycle unless pop or the queue stalls; n samples make a packet of 3n + 11 bytes.
//   the front takes a new sample every cycle until the command queue fills.
// reset
//   angle, packet position and crc clear, registers load defaults, queues
//   empty.
// stall
//   when pop stays low the output register holds, the byte walker waits,
//   the command queue fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module lidar_scan_packet_framer #(
    parameter int SAMPLES_PER_PACKET = lspf_pkg::SamplesPerPacketDefault,
    parameter int CMD_DEPTH          = lspf_pkg::CmdDepthDefault
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input queue
    input  logic                                push,
    output logic                                full,
    input  logic [15:0]                         distance_mm,
    // output queue
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          out_byte,
    output logic                                pkt_last,
    // configuration
    input  logic                                cfg_we,
    input  logic [lspf_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [lspf_pkg::CfgDataWidth-1:0]   cfg_data
);

    localparam logic [4:0] NSamp = lspf_pkg::clamp_samples(SAMPLES_PER_PACKET);
    localparam int CntWidth = $clog2(CMD_DEPTH+1);

    // configuration registers
    logic [15:0] angular_rate_reg;
    logic [31:0] angle_step_reg;
    logic [15:0] max_range_reg;
    logic [7:0]  confidence_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angular_rate_reg <= lspf_pkg::AngularRateReset;
            angle_step_reg   <= lspf_pkg::AngleStepReset;
            max_range_reg    <= lspf_pkg::MaxRangeReset;
            confidence_reg   <= lspf_pkg::ConfidenceReset;
        end
        else if (cfg_we)
        begin
            // indexes past the list are dropped
            unique case (cfg_index)
                lspf_pkg::CfgAngularRate: angular_rate_reg <= cfg_data[15:0];
                lspf_pkg::CfgAngleStep:   angle_step_reg   <= cfg_data[31:0];
                lspf_pkg::CfgMaxRange:    max_range_reg    <= cfg_data[15:0];
                lspf_pkg::CfgConfidence:  confidence_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // front to queue
    logic                  accept;
    lspf_pkg::cmd_t        front_cmd;
    logic [4:0]            front_pos;

    // queue to back
    lspf_pkg::cmd_t        head_cmd;
    logic                  head_valid;
    logic                  head_pop;
    logic                  fifo_full;
    logic [CntWidth-1:0]   fifo_count;

    // back status
    logic                  out_valid;
    lspf_pkg::back_stat_t  back_stat;

    // sample request taken when there is room for its command
    assign accept = push && !fifo_full;
    assign full   = fifo_full;
    assign empty  = !out_valid;

    lspf_front #(
        .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .distance_mm      (distance_mm),
        .angle_step       (angle_step_reg),
        .max_range_mm     (max_range_reg),
        .confidence_value (confidence_reg),
        .cmd              (front_cmd),
        .position         (front_pos)
    );

    lspf_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept),
        .wr_data   (front_cmd),
        .rd_en     (head_pop),
        .rd_data   (head_cmd),
        .not_empty (head_valid),
        .is_full   (fifo_full),
        .count     (fifo_count)
    );

    lspf_back #(
        .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (head_cmd),
        .cmd_valid        (head_valid),
        .cmd_pop          (head_pop),
        .angular_rate_dps (angular_rate_reg),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_byte         (out_byte),
        .pkt_last         (pkt_last),
        .stat             (back_stat)
    );

    // checks

    // packet position always inside the packet
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_pos < NSamp)
        else $error("packet position out of range");

    // a command being walked stays at the queue head
    a_active_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.active |-> (fifo_count != '0))
        else $error("byte walker active without a command");

    // an accepted sample lands in the queue
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (fifo_count != '0))
        else $error("accepted sample missing from queue");

    // walker never runs past the crc byte
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.active |-> (back_stat.step <= lspf_pkg::StepCrc))
        else $error("byte walker past end of packet");

endmodule

// ===== design/lspf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspf_front
// accepts samples, tracks angle and packet position, builds commands
// ----------------------------------------------------------------------------
module lspf_front #(
    parameter int SAMPLES_PER_PACKET = lspf_pkg::SamplesPerPacketDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [15:0]          distance_mm,
    input  logic [31:0]          angle_step,
    input  logic [15:0]          max_range_mm,
    input  logic [7:0]           confidence_value,
    output lspf_pkg::cmd_t       cmd,
    output logic [4:0]           position
);

    localparam logic [4:0] NSamp = lspf_pkg::clamp_samples(SAMPLES_PER_PACKET);

    logic [31:0] angle_reg, angle_next;
    logic [4:0]  pos_reg, pos_next;
    logic [32:0] sum;
    logic        trl;
    logic        over;

    // sum stays below three turns, so at most one of two corrections
    always_comb
    begin
        sum = {1'b0, angle_reg} + {1'b0, angle_step};
        if (sum >= lspf_pkg::TwoTurns)
            angle_next = 32'(sum - lspf_pkg::TwoTurns);
        else if (sum >= lspf_pkg::FullTurn)
            angle_next = 32'(sum - lspf_pkg::FullTurn);
        else
            angle_next = sum[31:0];
    end

    assign trl      = (pos_reg == NSamp - 5'd1);
    assign pos_next = trl ? 5'd0 : pos_reg + 5'd1;
    assign over     = (distance_mm > max_range_mm);

    always_comb
    begin
        cmd.hdr      = (pos_reg == 5'd0);
        cmd.trl      = trl;
        cmd.start_cd = angle_reg[31:16];
        cmd.end_cd   = angle_next[31:16];
        cmd.dist_mm  = over ? 16'd0 : distance_mm;
        cmd.conf     = over ? 8'd0 : confidence_value;
    end

    assign position = pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            angle_reg <= angle_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// ===== design/lspf_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspf_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module lspf_cmd_fifo #(
    parameter int DEPTH = lspf_pkg::CmdDepthDefault
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  lspf_pkg::cmd_t               wr_data,
    input  logic                         rd_en,
    output lspf_pkg::cmd_t               rd_data,
    output logic                         not_empty,
    output logic                         is_full,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH+1);
    localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

    lspf_pkg::cmd_t           entry_reg [DEPTH];
    logic [PtrWidth-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CntWidth-1:0]      count_reg, count_next;

    assign rd_data   = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign is_full   = (count_reg == FullCnt);
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)      count_next = count_reg + CntWidth'(1);
        else if (!wr_en && rd_en) count_next = count_reg - CntWidth'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en) wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrWidth'(1);
            if (rd_en) rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrWidth'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/lspf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspf_back
// walks the bytes of each command, keeps the crc, drives the output register
// ----------------------------------------------------------------------------
module lspf_back #(
    parameter int SAMPLES_PER_PACKET = lspf_pkg::SamplesPerPacketDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lspf_pkg::cmd_t        cmd,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  logic [15:0]           angular_rate_dps,
    input  logic                  pop,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  pkt_last,
    output lspf_pkg::back_stat_t  stat
);

    localparam logic [4:0] NSamp = lspf_pkg::clamp_samples(SAMPLES_PER_PACKET);

    logic       active_reg;
    logic [3:0] step_reg;
    logic [7:0] crc_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       pkt_last_reg;

    logic [3:0] cur_step, last_step;
    logic [7:0] crc_in, byte_val;
    logic       slot_free, emit, is_crc;

    assign cur_step  = active_reg ? step_reg
                     : (cmd.hdr ? lspf_pkg::StepPreamble : lspf_pkg::StepDistLo);
    assign last_step = cmd.trl ? lspf_pkg::StepCrc : lspf_pkg::StepConf;
    assign slot_free = !out_valid_reg || pop;
    assign emit      = cmd_valid && slot_free;
    assign cmd_pop   = emit && (cur_step == last_step);
    assign is_crc    = (cur_step == lspf_pkg::StepCrc);
    assign crc_in    = (cur_step == lspf_pkg::StepPreamble) ? 8'd0 : crc_reg;

    always_comb
    begin
        unique case (cur_step)
            lspf_pkg::StepPreamble: byte_val = lspf_pkg::Preamble;
            lspf_pkg::StepLength:   byte_val = lspf_pkg::LenVersion | {3'd0, NSamp};
            lspf_pkg::StepRateLo:   byte_val = angular_rate_dps[7:0];
            lspf_pkg::StepRateHi:   byte_val = angular_rate_dps[15:8];
            lspf_pkg::StepStartLo:  byte_val = cmd.start_cd[7:0];
            lspf_pkg::StepStartHi:  byte_val = cmd.start_cd[15:8];
            lspf_pkg::StepDistLo:   byte_val = cmd.dist_mm[7:0];
            lspf_pkg::StepDistHi:   byte_val = cmd.dist_mm[15:8];
            lspf_pkg::StepConf:     byte_val = cmd.conf;
            lspf_pkg::StepEndLo:    byte_val = cmd.end_cd[7:0];
            lspf_pkg::StepEndHi:    byte_val = cmd.end_cd[15:8];
            lspf_pkg::StepCrc:      byte_val = crc_in;
            default:                byte_val = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            step_reg      <= lspf_pkg::StepPreamble;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                active_reg    <= !cmd_pop;
                step_reg      <= cur_step + 4'd1;
                crc_reg       <= is_crc ? 8'd0 : lspf_pkg::crc_byte(crc_in, byte_val);
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= byte_val;
            pkt_last_reg <= is_crc;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign pkt_last    = pkt_last_reg;
    assign stat.active = active_reg;
    assign stat.step   = step_reg;

endmodule
